// ----- src/tlpq_pkg.sv -----
// Package for the three-class priority queue.
// Holds the controller state type, command and status structs and result codes.
// No dependencies.
package tlpq_pkg;

    localparam int NUM_CLASSES = 3;

    // Request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    // Result status codes
    localparam logic [2:0] STAT_INSERTED  = 3'd0;
    localparam logic [2:0] STAT_OVERFLOW  = 3'd1;
    localparam logic [2:0] STAT_INVALID   = 3'd2;
    localparam logic [2:0] STAT_REMOVED   = 3'd3;
    localparam logic [2:0] STAT_UNDERFLOW = 3'd4;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ
    } tlpq_state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;    // capture the incoming request
        logic rd_en;   // read the head entry of the chosen class
        logic commit;  // update queue state and load the result register
    } tlpq_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic is_delete;  // latched request is a delete
        logic out_free;   // result register can take a new result this cycle
    } tlpq_sts_t;

endpackage

// ----- src/tlpq_ctrl.sv -----
// Controller state machine for the three-class priority queue.
// Depends on tlpq_pkg for the state enum and the command/status structs.
module tlpq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tlpq_pkg::tlpq_sts_t  sts,
    output tlpq_pkg::tlpq_cmd_t  cmd
);
    import tlpq_pkg::*;

    tlpq_state_t state_reg;
    tlpq_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.is_delete) begin
                    // head entry comes out of the memory through a registered read, ready in ST_READ
                    cmd.rd_en  = 1'b1;
                    state_next = ST_READ;
                end else if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/tlpq_dp.sv -----
// Datapath for the three-class priority queue: request latch, per-class
// head/tail pointers, entry memory and result register. Uses tlpq_pkg.
module tlpq_dp #(
    parameter int DEPTH = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tlpq_pkg::tlpq_cmd_t  cmd,
    output tlpq_pkg::tlpq_sts_t  sts,
    input  logic                 req_type,
    input  logic signed [31:0]   value_in,
    input  logic [2:0]           class_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           status,
    output logic signed [31:0]   value_out,
    output logic [1:0]           class_out
);
    import tlpq_pkg::*;

    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MEM_DEPTH = NUM_CLASSES * DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] BASE1    = ADDR_W'(DEPTH);
    localparam logic [ADDR_W-1:0] BASE2    = ADDR_W'(2 * DEPTH);

    // Latched request
    logic              req_type_reg;
    logic signed [31:0] value_reg;
    logic [2:0]        class_reg;

    // Queue pointers
    logic [IDX_W-1:0]  head_reg [NUM_CLASSES];
    logic [IDX_W-1:0]  tail_reg [NUM_CLASSES];
    logic [IDX_W-1:0]  head_next [NUM_CLASSES];
    logic [IDX_W-1:0]  tail_next [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] nonempty_reg;
    logic [NUM_CLASSES-1:0] nonempty_next;

    // Entry memory
    logic [31:0]       mem [MEM_DEPTH];
    logic [31:0]       rd_data_reg;
    logic              we;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    // Result register
    logic              m_valid_reg;
    logic [2:0]        status_reg;
    logic signed [31:0] value_out_reg;
    logic [1:0]        class_out_reg;
    logic [2:0]        status_next;
    logic signed [31:0] value_out_next;
    logic [1:0]        class_out_next;

    // Insert decode
    logic              ins_cls_ok;
    logic [1:0]        iq;
    logic              ins_full;
    logic [IDX_W-1:0]  ins_idx;

    // Delete decode
    logic              del_any;
    logic [1:0]        dq;
    logic [IDX_W-1:0]  del_head;

    // Base address of a class region
    function automatic logic [ADDR_W-1:0] class_base(input logic [1:0] q);
        logic [ADDR_W-1:0] b;
        case (q)
            2'd0:    b = '0;
            2'd1:    b = BASE1;
            default: b = BASE2;
        endcase
        return b;
    endfunction

    // Request latch
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_type_reg <= req_type;
            value_reg    <= value_in;
            class_reg    <= class_in;
        end
    end

    // Insert: class check, tail position and overflow test
    always_comb begin
        ins_cls_ok = (class_reg == 3'd1) || (class_reg == 3'd2) || (class_reg == 3'd3);
        iq         = ins_cls_ok ? (class_reg[1:0] - 2'd1) : 2'd0;
        ins_full   = nonempty_reg[iq] && (tail_reg[iq] == LAST_IDX);
        ins_idx    = nonempty_reg[iq] ? (tail_reg[iq] + IDX_W'(1)) : '0;
        wr_addr    = class_base(iq) + ADDR_W'(ins_idx);
    end

    // Delete: lowest-numbered non-empty class
    always_comb begin
        del_any = |nonempty_reg;
        if (nonempty_reg[0]) begin
            dq = 2'd0;
        end else if (nonempty_reg[1]) begin
            dq = 2'd1;
        end else begin
            dq = 2'd2;
        end
        del_head = head_reg[dq];
        rd_addr  = class_base(dq) + ADDR_W'(del_head);
    end

    // Pointer updates and result on commit
    always_comb begin
        for (int i = 0; i < NUM_CLASSES; i++) begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
        end
        nonempty_next  = nonempty_reg;
        we             = 1'b0;
        status_next    = status_reg;
        value_out_next = value_out_reg;
        class_out_next = class_out_reg;
        if (cmd.commit) begin
            value_out_next = '0;
            class_out_next = 2'd0;
            if (req_type_reg == REQ_INSERT) begin
                if (!ins_cls_ok) begin
                    status_next = STAT_INVALID;
                end else if (ins_full) begin
                    status_next = STAT_OVERFLOW;
                end else begin
                    we            = 1'b1;
                    tail_next[iq] = ins_idx;
                    if (!nonempty_reg[iq]) begin
                        head_next[iq] = '0;
                    end
                    nonempty_next[iq] = 1'b1;
                    status_next       = STAT_INSERTED;
                    class_out_next    = class_reg[1:0];
                end
            end else begin
                if (!del_any) begin
                    status_next = STAT_UNDERFLOW;
                end else begin
                    // last entry out: queue empties and regains all slots
                    if (del_head == tail_reg[dq]) begin
                        head_next[dq]     = '0;
                        tail_next[dq]     = '0;
                        nonempty_next[dq] = 1'b0;
                    end else begin
                        head_next[dq] = del_head + IDX_W'(1);
                    end
                    status_next    = STAT_REMOVED;
                    value_out_next = rd_data_reg;
                    class_out_next = dq + 2'd1;
                end
            end
        end
    end

    // Pointer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
            nonempty_reg <= '0;
        end else begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
            end
            nonempty_reg <= nonempty_next;
        end
    end

    // Entry memory, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= value_reg;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg    <= status_next;
        value_out_reg <= value_out_next;
        class_out_reg <= class_out_next;
    end

    assign sts.is_delete = (req_type_reg == REQ_DELETE);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid   = m_valid_reg;
    assign status    = status_reg;
    assign value_out = value_out_reg;
    assign class_out = class_out_reg;

endmodule

// ----- src/three_level_priority_queue.sv -----
// Top level of the three-class priority queue: controller plus datapath.
// Depends on tlpq_pkg, tlpq_ctrl and tlpq_dp.
//
//  Channel | Handshake         | Payload
//  --------+-------------------+-----------------------------------------
//  s_      | s_valid / s_ready | s_req_type, s_value_in, s_class_in
//  m_      | m_valid / m_ready | m_status, m_value_out, m_class_out
//
// An insert is accepted in ST_IDLE and committed in ST_EXEC; its result is
// valid once the commit has loaded the result register. A delete issues the
// registered read of the entry memory in ST_EXEC and commits in ST_READ, so
// its result is built from the read data.
// The result register frees the input side: a new request is taken while
// an earlier result is still waiting on m_ready, and only the commit step
// stalls on it. Reset empties all three queues; memory contents are not cleared.
module three_level_priority_queue #(
    parameter int DEPTH = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic signed [31:0]  s_value_in,
    input  logic [2:0]          s_class_in,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic signed [31:0]  m_value_out,
    output logic [1:0]          m_class_out
);
    import tlpq_pkg::*;

    tlpq_cmd_t cmd;
    tlpq_sts_t sts;

    tlpq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tlpq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .req_type  (s_req_type),
        .value_in  (s_value_in),
        .class_in  (s_class_in),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .status    (m_status),
        .value_out (m_value_out),
        .class_out (m_class_out)
    );

endmodule
